[design/fct_pkg.sv]
// fct_pkg: shared constants, operation codes and plane layout for the frustum culler
// no dependencies
package fct_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int NUM_PLANES      = 6;
    localparam int NUM_AXES        = 3;
    localparam int NUM_ROWS        = 4;
    localparam int NUM_COMPS       = 4;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_POINT  = 2'd1,
        OP_SPHERE = 2'd2,
        OP_BOX    = 2'd3
    } t_op;

    localparam logic [1:0] ROW_D = 2'd3;

    // planes 1, 2 and 4 take the difference d - row, the rest the sum
    localparam logic [NUM_PLANES-1:0] PLANE_SUB = 6'b010110;

    function automatic logic [1:0] plane_src(input int unsigned idx);
        logic [31:0] v;
        v = 32'(idx) >> 1;
        return v[1:0];
    endfunction

endpackage

[design/fct_plane_store.sv]
// fct_plane_store: matrix vector registers and the six rebuilt plane coefficients
// depends on fct_pkg
module fct_plane_store #(
    parameter int CW = fct_pkg::COORD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [1:0]           i_row,
    input  logic signed [CW-1:0] i_vec   [fct_pkg::NUM_COMPS],
    output logic signed [CW:0]   o_plane [fct_pkg::NUM_PLANES][fct_pkg::NUM_COMPS]
);

    logic signed [CW-1:0] r_mstore [fct_pkg::NUM_ROWS][fct_pkg::NUM_COMPS];
    logic signed [CW-1:0] n_mstore [fct_pkg::NUM_ROWS][fct_pkg::NUM_COMPS];
    logic signed [CW:0]   r_plane  [fct_pkg::NUM_PLANES][fct_pkg::NUM_COMPS];
    logic signed [CW:0]   n_plane  [fct_pkg::NUM_PLANES][fct_pkg::NUM_COMPS];

    always_comb begin
        n_mstore = r_mstore;
        if (i_we) begin
            n_mstore[i_row] = i_vec;
        end
        for (int i = 0; i < fct_pkg::NUM_PLANES; i++) begin
            for (int k = 0; k < fct_pkg::NUM_COMPS; k++) begin
                if (fct_pkg::PLANE_SUB[i]) begin
                    n_plane[i][k] = (CW+1)'(n_mstore[fct_pkg::ROW_D][k])
                                  - (CW+1)'(n_mstore[fct_pkg::plane_src(i)][k]);
                end else begin
                    n_plane[i][k] = (CW+1)'(n_mstore[fct_pkg::ROW_D][k])
                                  + (CW+1)'(n_mstore[fct_pkg::plane_src(i)][k]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < fct_pkg::NUM_ROWS; r++) begin
                for (int k = 0; k < fct_pkg::NUM_COMPS; k++) begin
                    r_mstore[r][k] <= '0;
                end
            end
            for (int i = 0; i < fct_pkg::NUM_PLANES; i++) begin
                for (int k = 0; k < fct_pkg::NUM_COMPS; k++) begin
                    r_plane[i][k] <= '0;
                end
            end
        end else if (i_we) begin
            r_mstore <= n_mstore;
            r_plane  <= n_plane;
        end
    end

    assign o_plane = r_plane;

endmodule

[design/fct_dist_pipe.sv]
// fct_dist_pipe: plane distance pipeline, products, partial sums, sign and verdict
// depends on fct_pkg
module fct_dist_pipe #(
    parameter int CW = fct_pkg::COORD_WIDTH_DEF,
    parameter int FB = fct_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [CW-1:0] i_lo    [fct_pkg::NUM_AXES],
    input  logic signed [CW-1:0] i_hi    [fct_pkg::NUM_AXES],
    input  logic [CW-2:0]        i_bias,
    input  logic signed [CW:0]   i_plane [fct_pkg::NUM_PLANES][fct_pkg::NUM_COMPS],
    input  logic                 i_stall,
    output logic                 o_ready,
    output logic                 o_valid,
    output logic                 o_visible
);

    localparam int DW = CW + FB + 2;
    localparam int PW = 2 * CW + 1;
    localparam int AW = ((DW > PW) ? DW : PW) + 3;

    logic en2, en3, en4;
    logic r_v2, r_v3, r_v4;

    logic signed [PW-1:0] n_prod  [fct_pkg::NUM_PLANES][fct_pkg::NUM_AXES];
    logic signed [PW-1:0] r2_prod [fct_pkg::NUM_PLANES][fct_pkg::NUM_AXES];
    logic signed [AW-1:0] n_dterm [fct_pkg::NUM_PLANES];
    logic signed [AW-1:0] r2_dterm[fct_pkg::NUM_PLANES];
    logic signed [AW-1:0] r3_a    [fct_pkg::NUM_PLANES];
    logic signed [AW-1:0] r3_b    [fct_pkg::NUM_PLANES];
    logic signed [CW-1:0] w_coord [fct_pkg::NUM_PLANES][fct_pkg::NUM_AXES];
    logic signed [AW-1:0] w_sum   [fct_pkg::NUM_PLANES];
    logic [fct_pkg::NUM_PLANES-1:0] w_pass;
    logic r_vis;

    assign en4 = !r_v4 || !i_stall;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign o_ready = en2;

    // corner picked by the sign of each normal component
    always_comb begin
        for (int i = 0; i < fct_pkg::NUM_PLANES; i++) begin
            for (int k = 0; k < fct_pkg::NUM_AXES; k++) begin
                w_coord[i][k] = i_plane[i][k][CW] ? i_lo[k] : i_hi[k];
                n_prod[i][k]  = PW'(i_plane[i][k]) * PW'(w_coord[i][k]);
            end
            n_dterm[i] = (AW'(i_plane[i][3]) + AW'({1'b0, i_bias})) << FB;
        end
    end

    always_comb begin
        for (int i = 0; i < fct_pkg::NUM_PLANES; i++) begin
            w_sum[i]  = r3_a[i] + r3_b[i];
            w_pass[i] = !w_sum[i][AW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en2) begin
                r_v2 <= i_valid;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_prod  <= n_prod;
            r2_dterm <= n_dterm;
        end
        if (en3) begin
            for (int i = 0; i < fct_pkg::NUM_PLANES; i++) begin
                r3_a[i] <= AW'(r2_prod[i][0]) + AW'(r2_prod[i][1]);
                r3_b[i] <= AW'(r2_prod[i][2]) + r2_dterm[i];
            end
        end
        if (en4) begin
            r_vis <= &w_pass;
        end
    end

    assign o_valid   = r_v4;
    assign o_visible = r_vis;

endmodule

[design/frustum_cull_test_unit.sv]
// frustum_cull_test_unit: top level of the fixed-point view-frustum culler
// depends on fct_pkg, fct_plane_store and fct_dist_pipe
//
// usage
//   input channel: i_valid / o_stall carry one request: a matrix vector load or a
//   point, sphere or box test. a request is taken at an edge with i_valid high and
//   o_stall low
//   output channel: o_valid / i_stall carry one verdict per test, o_visible high if
//   the object lies inside all six planes. loads give no verdict
//   a taken test moves through the products, partial sums and verdict registers to o_valid
//   throughput: one request per cycle while o_stall is low; four register stages
//   (input, products, partial sums, verdict) each hold their own valid bit
//   a load commits in the input stage, so a test taken after a load sees the new
//   planes and a test taken before it still sees the old ones
//   reset clears the matrix, the planes (every test then passes) and all valid bits
//   when the receiver stalls, bubbles in the pipe still fill; o_stall rises only once
//   every stage holds a test and the verdict waits
module frustum_cull_test_unit #(
    parameter int COORD_WIDTH = fct_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = fct_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_operation,
    input  logic [1:0]                    i_row_select,
    input  logic signed [COORD_WIDTH-1:0] i_vec_x,
    input  logic signed [COORD_WIDTH-1:0] i_vec_y,
    input  logic signed [COORD_WIDTH-1:0] i_vec_z,
    input  logic signed [COORD_WIDTH-1:0] i_vec_w,
    input  logic signed [COORD_WIDTH-1:0] i_max_x,
    input  logic signed [COORD_WIDTH-1:0] i_max_y,
    input  logic signed [COORD_WIDTH-1:0] i_max_z,
    input  logic [COORD_WIDTH-2:0]        i_radius,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_visible
);

    localparam int CW = COORD_WIDTH;

    logic r1_v, r1_load;
    logic [1:0] r1_row;
    logic signed [CW-1:0] r1_lo [fct_pkg::NUM_AXES];
    logic signed [CW-1:0] r1_hi [fct_pkg::NUM_AXES];
    logic signed [CW-1:0] r1_w;
    logic [CW-2:0] r1_bias;

    logic signed [CW-1:0] n_lo  [fct_pkg::NUM_AXES];
    logic signed [CW-1:0] n_hi  [fct_pkg::NUM_AXES];
    logic [CW-2:0]        n_bias;
    logic signed [CW-1:0] w_min [fct_pkg::NUM_AXES];
    logic signed [CW-1:0] w_max [fct_pkg::NUM_AXES];
    logic signed [CW-1:0] w_ldvec [fct_pkg::NUM_COMPS];
    logic signed [CW:0]   w_plane [fct_pkg::NUM_PLANES][fct_pkg::NUM_COMPS];
    fct_pkg::t_op w_op;
    logic pipe_ready, accept, plane_we;

    assign w_op   = fct_pkg::t_op'(i_operation);
    assign w_min  = '{i_vec_x, i_vec_y, i_vec_z};
    assign w_max  = '{i_max_x, i_max_y, i_max_z};

    assign o_stall  = r1_v && !r1_load && !pipe_ready;
    assign accept   = i_valid && !o_stall;
    assign plane_we = r1_v && r1_load;

    always_comb begin
        n_bias = '0;
        for (int k = 0; k < fct_pkg::NUM_AXES; k++) begin
            n_lo[k] = w_min[k];
            n_hi[k] = w_min[k];
        end
        case (w_op)
            fct_pkg::OP_SPHERE: begin
                n_bias = i_radius;
            end
            fct_pkg::OP_BOX: begin
                for (int k = 0; k < fct_pkg::NUM_AXES; k++) begin
                    if (w_max[k] > w_min[k]) begin
                        n_hi[k] = w_max[k];
                    end else begin
                        n_lo[k] = w_max[k];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (!o_stall) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_load <= (w_op == fct_pkg::OP_LOAD);
            r1_row  <= i_row_select;
            r1_lo   <= n_lo;
            r1_hi   <= n_hi;
            r1_w    <= i_vec_w;
            r1_bias <= n_bias;
        end
    end

    assign w_ldvec = '{r1_lo[0], r1_lo[1], r1_lo[2], r1_w};

    fct_plane_store #(
        .CW (CW)
    ) u_planes (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (plane_we),
        .i_row   (r1_row),
        .i_vec   (w_ldvec),
        .o_plane (w_plane)
    );

    fct_dist_pipe #(
        .CW (CW),
        .FB (FRAC_BITS)
    ) u_pipe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r1_v && !r1_load),
        .i_lo      (r1_lo),
        .i_hi      (r1_hi),
        .i_bias    (r1_bias),
        .i_plane   (w_plane),
        .i_stall   (i_stall),
        .o_ready   (pipe_ready),
        .o_valid   (o_valid),
        .o_visible (o_visible)
    );

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid && !r1_v)
        else $error("pipe not empty after reset");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall && r1_v))
        else $error("input stalled while the pipe has room");

    a_load_commits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r1_v && r1_load) |-> !o_stall)
        else $error("load held in the input stage");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r1_v && r1_load && pipe_ready) |=> !$past(o_stall))
        else $error("load blocked the input");

endmodule

[dv/frustum_cull_checker.sv]
// frustum_cull_checker: watches both channels of the frustum culler, keeps its own
// matrix and planes, predicts each verdict and compares; depends on fct_pkg
module frustum_cull_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_stall_in,
    input  logic [1:0]        i_operation,
    input  logic [1:0]        i_row_select,
    input  logic [31:0]       i_vec_x,
    input  logic [31:0]       i_vec_y,
    input  logic [31:0]       i_vec_z,
    input  logic [31:0]       i_vec_w,
    input  logic [31:0]       i_max_x,
    input  logic [31:0]       i_max_y,
    input  logic [31:0]       i_max_z,
    input  logic [30:0]       i_radius,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic              i_visible,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [31:0] mat [16];
    logic signed [32:0] pln [24];
    bit verdicts [$];

    assign o_pending = verdicts.size();

    function automatic void rebuild_planes();
        logic signed [32:0] a, b, c, d;
        for (int k = 0; k < 4; k++) begin
            a = mat[k];
            b = mat[4 + k];
            c = mat[8 + k];
            d = mat[12 + k];
            pln[k]      = d + a;
            pln[4 + k]  = d - a;
            pln[8 + k]  = d - b;
            pln[12 + k] = d + b;
            pln[16 + k] = d - c;
            pln[20 + k] = d + c;
        end
    endfunction

    function automatic bit plane_below(int pl, logic signed [31:0] p [3],
                                       logic signed [31:0] bias);
        logic signed [127:0] acc;
        acc = (128'(signed'(pln[pl * 4 + 3])) + 128'(bias)) <<< fct_pkg::FRAC_BITS_DEF;
        for (int k = 0; k < 3; k++)
            acc = acc + 128'(pln[pl * 4 + k]) * 128'(p[k]);
        return acc < 0;
    endfunction

    function automatic bit culler_verdict(fct_pkg::t_op op, logic signed [31:0] lo [3],
                                          logic signed [31:0] hi [3],
                                          logic signed [31:0] rad);
        logic signed [31:0] c [3];
        for (int i = 0; i < fct_pkg::NUM_PLANES; i++) begin
            case (op)
                fct_pkg::OP_POINT: if (plane_below(i, lo, 0)) return 0;
                fct_pkg::OP_SPHERE: if (plane_below(i, lo, rad)) return 0;
                default: begin
                    for (int k = 0; k < 3; k++) begin
                        if (pln[i * 4 + k] < 0)
                            c[k] = (hi[k] > lo[k]) ? lo[k] : hi[k];
                        else
                            c[k] = (hi[k] > lo[k]) ? hi[k] : lo[k];
                    end
                    if (plane_below(i, c, 0)) return 0;
                end
            endcase
        end
        return 1;
    endfunction

    always @(posedge i_clk) begin
        logic signed [31:0] lo [3];
        logic signed [31:0] hi [3];
        bit exp_vis;
        if (!i_rst_n) begin
            foreach (mat[i]) mat[i] = '0;
            foreach (pln[i]) pln[i] = '0;
            verdicts.delete();
            o_fail_count <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (verdicts.size() == 0) begin
                    $error("verdict with none expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_vis = verdicts.pop_front();
                    if (exp_vis != i_visible) begin
                        $error("visible: expected %0d actual %0d", exp_vis, i_visible);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_valid && !i_stall_in) begin
                if (fct_pkg::t_op'(i_operation) == fct_pkg::OP_LOAD) begin
                    mat[i_row_select * 4 + 0] = i_vec_x;
                    mat[i_row_select * 4 + 1] = i_vec_y;
                    mat[i_row_select * 4 + 2] = i_vec_z;
                    mat[i_row_select * 4 + 3] = i_vec_w;
                    rebuild_planes();
                end else begin
                    lo[0] = i_vec_x; lo[1] = i_vec_y; lo[2] = i_vec_z;
                    hi[0] = i_max_x; hi[1] = i_max_y; hi[2] = i_max_z;
                    verdicts.push_back(culler_verdict(fct_pkg::t_op'(i_operation), lo, hi,
                                                      {1'b0, i_radius}));
                end
            end
        end
    end
endmodule

[dv/tb_frustum_cull_test_unit.sv]
// tb_frustum_cull_test_unit: stimulus and verdict for the frustum culler
// depends on fct_pkg, frustum_cull_test_unit and frustum_cull_checker
module tb_frustum_cull_test_unit;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk, i_rst_n, i_valid, o_stall, o_valid, i_stall, o_visible;
    logic [1:0] i_operation, i_row_select;
    logic signed [31:0] i_vec_x, i_vec_y, i_vec_z, i_vec_w, i_max_x, i_max_y, i_max_z;
    logic [30:0] i_radius;
    int fail_count, pending;
    bit stall_on;

    frustum_cull_test_unit u_top (.*);

    frustum_cull_checker u_chk (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall), .i_operation, .i_row_select,
        .i_vec_x, .i_vec_y, .i_vec_z, .i_vec_w, .i_max_x, .i_max_y, .i_max_z, .i_radius,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_visible(o_visible),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    // receiver stall pattern, with quiet stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 0;
        end else begin
            if ($urandom_range(0, 63) == 0) stall_on <= !stall_on;
            i_stall <= stall_on ? ($urandom_range(0, 2) == 0) : 1'b0;
        end
    end

    function automatic logic [31:0] coord_val(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'sh8000_0000;
            2: return 32'sh7fff_ffff;
            3: return 0;
            4: return $urandom_range(0, 'h3ffff) - 'h20000;
            default: return $urandom_range(0, 'hfffff) - 'h80000;
        endcase
    endfunction

    task automatic send_request(fct_pkg::t_op op, int row, logic [31:0] x, logic [31:0] y,
                                logic [31:0] z, logic [31:0] w, logic [31:0] mx,
                                logic [31:0] my, logic [31:0] mz, int rad);
        i_valid <= 1;
        i_operation <= op;
        i_row_select <= 2'(row);
        i_vec_x <= x; i_vec_y <= y; i_vec_z <= z; i_vec_w <= w;
        i_max_x <= mx; i_max_y <= my; i_max_z <= mz;
        i_radius <= 31'(rad);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic rand_request(int mode);
        fct_pkg::t_op op;
        op = ($urandom_range(0, 5) == 0) ? fct_pkg::OP_LOAD
                                          : fct_pkg::t_op'($urandom_range(1, 3));
        send_request(op, int'($urandom_range(0, 3)), coord_val(mode), coord_val(mode),
                     coord_val(mode), coord_val(mode), coord_val(mode), coord_val(mode),
                     coord_val(mode),
                     (mode == 0) ? int'($urandom_range(0, 32'h7fff_ffff))
                                 : int'($urandom_range(0, 'h40000)));
    endtask

    task automatic gap();
        int n;
        n = $urandom_range(0, 3);
        if (n != 0) begin
            i_valid <= 0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    initial begin
        int mode, burst;
        i_rst_n = 0; i_valid = 0; i_operation = 0; i_row_select = 0;
        i_vec_x = 0; i_vec_y = 0; i_vec_z = 0; i_vec_w = 0;
        i_max_x = 0; i_max_y = 0; i_max_z = 0; i_radius = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // after reset every test is visible
        send_request(fct_pkg::OP_POINT, 0, 32'sh8000_0000, 32'sh7fff_ffff, 0, 0, 0, 0, 0, 0);
        send_request(fct_pkg::OP_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0, '1);
        send_request(fct_pkg::OP_BOX, 0, 32'sh7fff_ffff, 0, 0, 0, 32'sh8000_0000, 0, 0, 0);
        // extremes in the matrix
        send_request(fct_pkg::OP_LOAD, 0, 32'sh8000_0000, 32'sh7fff_ffff, '1, 32'sh8000_0000,
                     0, 0, 0, 0);
        send_request(fct_pkg::OP_LOAD, 3, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh0001_0000,
                     32'sh7fff_ffff, 0, 0, 0, 0);
        send_request(fct_pkg::OP_POINT, 0, 32'sh7fff_ffff, 32'sh8000_0000, '1, 0, 0, 0, 0, 0);
        send_request(fct_pkg::OP_SPHERE, 0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0,
                     0, 0, 0, 32'h7fff_ffff);
        // simple unit frustum around the origin
        send_request(fct_pkg::OP_LOAD, 0, 32'sh0001_0000, 0, 0, 0, 0, 0, 0, 0);
        send_request(fct_pkg::OP_LOAD, 1, 0, 32'sh0001_0000, 0, 0, 0, 0, 0, 0);
        send_request(fct_pkg::OP_LOAD, 2, 0, 0, 32'sh0001_0000, 0, 0, 0, 0, 0);
        send_request(fct_pkg::OP_LOAD, 3, 0, 0, 0, 32'sh0001_0000, 0, 0, 0, 0);
        send_request(fct_pkg::OP_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_request(fct_pkg::OP_POINT, 0, 32'sh0002_0000, 0, 0, 0, 0, 0, 0, 0);
        send_request(fct_pkg::OP_SPHERE, 0, 32'sh0002_0000, 0, 0, 0, 0, 0, 0, 32'h0001_0000);
        send_request(fct_pkg::OP_SPHERE, 0, 32'sh0003_0000, 0, 0, 0, 0, 0, 0, 32'h0001_0000);
        send_request(fct_pkg::OP_BOX, 0, 32'sh0002_0000, 0, 0, 0, 32'sh0005_0000, 0, 0, 0);
        // inverted box
        send_request(fct_pkg::OP_BOX, 0, 32'sh0005_0000, 0, 0, 0, 32'sh0000_8000, 0, 0, 0);
        send_request(fct_pkg::OP_BOX, 0, 32'sh0005_0000, 32'sh0005_0000, 0, 0,
                     32'sh0003_0000, 32'sh0003_0000, 0, 0);
        send_request(fct_pkg::OP_BOX, 0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0,
                     32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0);

        for (int n = 0; n < 400; ) begin
            burst = $urandom_range(1, 16);
            mode = $urandom_range(0, 5);
            for (int b = 0; b < burst; b++) begin
                rand_request(mode);
                n++;
            end
            gap();
        end
        i_valid <= 0;

        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
